>>> hdl/bia_pkg.sv
// Shared types, constants and helpers for the bitmap ID allocator.
`default_nettype none

package bia_pkg;

    localparam int CAPACITY     = 1024;
    localparam int WORD_BITS    = 64;
    localparam int CONTEXT_BITS = 32;
    localparam int WORD_COUNT   = (CAPACITY + WORD_BITS - 1) / WORD_BITS;
    localparam int INDEX_W      = 10;
    localparam int COUNT_W      = $clog2(CAPACITY + 1);
    localparam int WORD_IDX_W   = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
    localparam int BIT_IDX_W    = $clog2(WORD_BITS);

    typedef enum logic [1:0] {
        KIND_GET    = 2'd0,
        KIND_PUT    = 2'd1,
        KIND_LOOKUP = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK         = 2'd0,
        STATUS_NONE_FREE  = 2'd1,
        STATUS_NO_CONTEXT = 2'd2,
        STATUS_BAD        = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_SCAN,
        S_CHECK
    } fsm_state_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  target_index;
        logic [31:0] context_value;
    } in_req_t;

    typedef struct packed {
        status_t     status;
        logic [9:0]  granted_index;
        logic [31:0] context_out;
    } out_rsp_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;
        logic cfg_write;
        logic scan_step;
        logic scan_commit;
        logic check_commit;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic [1:0] kind;
        logic       word_nonzero;
        logic       scan_last;
        logic       used_full;
    } dp_status_t;

    // Free-map word w after init with an ID count of count (IDs below count free)
    function automatic logic [WORD_BITS-1:0] init_word(input logic [COUNT_W-1:0] count,
                                                       input int w);
        int base;
        int cnt;
        logic [WORD_BITS-1:0] word;
        base = w * WORD_BITS;
        cnt  = int'(count);
        if (cnt >= base + WORD_BITS) begin
            word = '1;
        end
        else if (cnt <= base) begin
            word = '0;
        end
        else begin
            word = ~({WORD_BITS{1'b1}} << (cnt - base));
        end
        return word;
    endfunction

endpackage

`default_nettype wire

>>> hdl/bia_datapath.sv
// Datapath of the bitmap ID allocator: free map, context memory, counters, result register.
`default_nettype none

module bia_datapath (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire bia_pkg::ctrl_cmd_t            cmd,
    input  wire bia_pkg::in_req_t              in_data,
    input  wire logic [bia_pkg::COUNT_W-1:0]   cfg_data,
    output bia_pkg::dp_status_t                dp_status,
    output bia_pkg::out_rsp_t                  out_data
);

    bia_pkg::in_req_t                            req_reg;
    logic [bia_pkg::WORD_IDX_W-1:0]              ptr_reg;
    logic [bia_pkg::WORD_IDX_W-1:0]              ptr_next;
    logic [bia_pkg::WORD_BITS-1:0]               free_map_reg  [bia_pkg::WORD_COUNT];
    logic [bia_pkg::WORD_BITS-1:0]               free_map_next [bia_pkg::WORD_COUNT];
    logic [bia_pkg::COUNT_W-1:0]                 used_reg;
    logic [bia_pkg::COUNT_W-1:0]                 used_next;
    logic [bia_pkg::COUNT_W-1:0]                 id_count_reg;
    logic [bia_pkg::COUNT_W-1:0]                 id_count_next;
    bia_pkg::out_rsp_t                           rsp_reg;
    bia_pkg::out_rsp_t                           rsp_next;
    logic [bia_pkg::CONTEXT_BITS-1:0]            ctx_mem [bia_pkg::CAPACITY];
    logic [bia_pkg::CONTEXT_BITS-1:0]            mem_rd_reg;

    logic [bia_pkg::WORD_IDX_W-1:0]              word_sel;
    logic [bia_pkg::WORD_BITS-1:0]               cur_word;
    logic [bia_pkg::BIT_IDX_W-1:0]               ffs;
    logic [bia_pkg::BIT_IDX_W-1:0]               req_bit;
    logic [bia_pkg::INDEX_W-1:0]                 grant_id;
    logic [bia_pkg::CONTEXT_BITS-1:0]            req_ctx;
    logic                                        idx_bad;
    logic                                        grant_ok;
    logic [bia_pkg::COUNT_W-1:0]                 cfg_sat;

    assign req_ctx  = bia_pkg::CONTEXT_BITS'(req_reg.context_value);
    assign req_bit  = bia_pkg::BIT_IDX_W'(req_reg.target_index);
    assign word_sel = (req_reg.kind == bia_pkg::KIND_GET) ? ptr_reg :
                      bia_pkg::WORD_IDX_W'(req_reg.target_index >> bia_pkg::BIT_IDX_W);
    assign cur_word = free_map_reg[word_sel];
    assign grant_id = bia_pkg::INDEX_W'({ptr_reg, ffs});
    assign idx_bad  = ({1'b0, req_reg.target_index} >= id_count_reg);
    assign grant_ok = !dp_status.used_full && dp_status.word_nonzero;

    // Lowest set bit of the selected word
    always_comb
    begin
        ffs = '0;
        for (int b = bia_pkg::WORD_BITS - 1; b >= 0; b--)
        begin
            if (cur_word[b])
            begin
                ffs = bia_pkg::BIT_IDX_W'(b);
            end
        end
    end

    always_comb
    begin
        if (cfg_data == '0)
        begin
            cfg_sat = bia_pkg::COUNT_W'(1);
        end
        else if (cfg_data > bia_pkg::COUNT_W'(bia_pkg::CAPACITY))
        begin
            cfg_sat = bia_pkg::COUNT_W'(bia_pkg::CAPACITY);
        end
        else
        begin
            cfg_sat = cfg_data;
        end
    end

    assign dp_status.kind         = req_reg.kind;
    assign dp_status.word_nonzero = (cur_word != '0);
    assign dp_status.scan_last    = (ptr_reg == bia_pkg::WORD_IDX_W'(bia_pkg::WORD_COUNT - 1));
    assign dp_status.used_full    = (used_reg >= id_count_reg);

    always_comb
    begin
        free_map_next = free_map_reg;
        used_next     = used_reg;
        id_count_next = id_count_reg;
        rsp_next      = rsp_reg;
        ptr_next      = ptr_reg;

        if (cmd.load)
        begin
            ptr_next = '0;
        end
        if (cmd.scan_step)
        begin
            ptr_next = ptr_reg + 1'b1;
        end

        if (cmd.scan_commit)
        begin
            rsp_next.status        = bia_pkg::STATUS_NONE_FREE;
            rsp_next.granted_index = '0;
            rsp_next.context_out   = '0;
            if (grant_ok)
            begin
                free_map_next[ptr_reg][ffs] = 1'b0;
                used_next                   = used_reg + 1'b1;
                rsp_next.status             = bia_pkg::STATUS_OK;
                rsp_next.granted_index      = grant_id;
            end
        end

        if (cmd.check_commit)
        begin
            rsp_next.status        = bia_pkg::STATUS_BAD;
            rsp_next.granted_index = '0;
            rsp_next.context_out   = '0;
            case (req_reg.kind)
                bia_pkg::KIND_PUT:
                begin
                    if (!idx_bad && !cur_word[req_bit] && mem_rd_reg == req_ctx)
                    begin
                        free_map_next[word_sel][req_bit] = 1'b1;
                        if (used_reg != '0)
                        begin
                            used_next = used_reg - 1'b1;
                        end
                        rsp_next.status = bia_pkg::STATUS_OK;
                    end
                end
                bia_pkg::KIND_LOOKUP:
                begin
                    if (idx_bad)
                    begin
                        rsp_next.status = bia_pkg::STATUS_BAD;
                    end
                    else if (cur_word[req_bit] || mem_rd_reg == '0)
                    begin
                        rsp_next.status = bia_pkg::STATUS_NO_CONTEXT;
                    end
                    else
                    begin
                        rsp_next.status      = bia_pkg::STATUS_OK;
                        rsp_next.context_out = 32'(mem_rd_reg);
                    end
                end
                default:
                begin
                    rsp_next.status = bia_pkg::STATUS_BAD;
                end
            endcase
        end

        // Re-init on a count write; stale tags are masked by the free bits
        if (cmd.cfg_write)
        begin
            id_count_next = cfg_sat;
            used_next     = '0;
            for (int w = 0; w < bia_pkg::WORD_COUNT; w++)
            begin
                free_map_next[w] = bia_pkg::init_word(cfg_sat, w);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg     <= '0;
            id_count_reg <= bia_pkg::COUNT_W'(bia_pkg::CAPACITY);
            for (int w = 0; w < bia_pkg::WORD_COUNT; w++)
            begin
                free_map_reg[w] <= bia_pkg::init_word(bia_pkg::COUNT_W'(bia_pkg::CAPACITY), w);
            end
        end
        else
        begin
            used_reg     <= used_next;
            id_count_reg <= id_count_next;
            free_map_reg <= free_map_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ptr_reg <= ptr_next;
        rsp_reg <= rsp_next;
        if (cmd.load)
        begin
            req_reg <= in_data;
        end
    end

    // Context memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.scan_commit && grant_ok)
        begin
            ctx_mem[grant_id] <= req_ctx;
        end
        mem_rd_reg <= ctx_mem[req_reg.target_index];
    end

    assign out_data = rsp_reg;

endmodule

`default_nettype wire

>>> hdl/bia_ctrl.sv
// Controller state machine of the bitmap ID allocator.
`default_nettype none

module bia_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire bia_pkg::dp_status_t  dp_status,
    output bia_pkg::ctrl_cmd_t        cmd
);

    bia_pkg::fsm_state_t state_reg;
    bia_pkg::fsm_state_t state_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    logic                slot_free;

    assign slot_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bia_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        cfg_ready  = 1'b0;

        case (state_reg)
            bia_pkg::S_IDLE:
            begin
                in_ready      = 1'b1;
                cfg_ready     = 1'b1;
                cmd.cfg_write = cfg_valid;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bia_pkg::S_READ;
                end
            end
            bia_pkg::S_READ:
            begin
                if (dp_status.kind == bia_pkg::KIND_GET)
                begin
                    state_next = bia_pkg::S_SCAN;
                end
                else
                begin
                    state_next = bia_pkg::S_CHECK;
                end
            end
            bia_pkg::S_SCAN:
            begin
                if (slot_free)
                begin
                    if (dp_status.used_full || dp_status.word_nonzero || dp_status.scan_last)
                    begin
                        cmd.scan_commit = 1'b1;
                        state_next      = bia_pkg::S_IDLE;
                    end
                    else
                    begin
                        cmd.scan_step = 1'b1;
                    end
                end
            end
            bia_pkg::S_CHECK:
            begin
                if (slot_free)
                begin
                    cmd.check_commit = 1'b1;
                    state_next       = bia_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bia_pkg::S_IDLE;
            end
        endcase

        if (cmd.scan_commit || cmd.check_commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

>>> hdl/bitmap_id_allocator_top.sv
// Top level of the bitmap ID allocator: controller, datapath and checks.
// Hands out IDs from a free map of 16 words of 64 bits and keeps a 32-bit tag per ID in a
// 1024-entry memory. After acceptance, a get request scans the free-map words, one per
// cycle while the output register can take a result, up to the first word with a free ID
// (1 to 16 words). Put and lookup requests wait for the registered read of the tag memory
// and then check it. One request is in work at a time; the next one is accepted in the
// cycle after a result is loaded into the output register, even while that result still
// waits for out_ready. A write of id_count (saturated into 1..1024) re-initializes the
// free map and the use count, so no clearing pass over the tag memory is needed: tags of
// free IDs are never used. Write id_count only while the block is idle.
`default_nettype none

module bitmap_id_allocator_top (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire bia_pkg::in_req_t              in_data,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output bia_pkg::out_rsp_t                  out_data,
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [bia_pkg::COUNT_W-1:0]   cfg_data
);

    bia_pkg::ctrl_cmd_t  cmd;
    bia_pkg::dp_status_t dp_status;

    // Sequence each request: accept, read, then scan or check
    bia_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .dp_status (dp_status),
        .cmd       (cmd)
    );

    // Hold the free map, tags, counters and the result register
    bia_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_data   (in_data),
        .cfg_data  (cfg_data),
        .dp_status (dp_status),
        .out_data  (out_data)
    );

    // An accepted request makes the block busy in the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("request accepted while a request was still in work");

    // No result can appear in the cycle right after a request is accepted
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !out_valid) |=> !out_valid)
        else $error("result produced without working the request");

    // Only a successful get carries an index, only a successful lookup a tag
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.status != bia_pkg::STATUS_OK)
            |-> (out_data.granted_index == '0 && out_data.context_out == '0))
        else $error("failed request returned an index or a tag");

endmodule

`default_nettype wire
